// ===== sv/u8v_pkg.sv =====
// Constants for the UTF-8 stream checker: code point limits and byte masks.
// No dependencies; imported by utf8_stream_validator.
package u8v_pkg;

  localparam int unsigned CP_W = 21;

  // Code point limits
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_2BYTE   = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3BYTE   = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4BYTE   = 21'h010000;

  // Byte classes
  localparam logic [7:0] ASCII_DEL   = 8'h7F;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_TOP   = 8'h80;
  localparam logic [7:0] MASK_LEAD2  = 8'hE0;
  localparam logic [7:0] MASK_LEAD3  = 8'hF0;
  localparam logic [7:0] MASK_LEAD4  = 8'hF8;
  localparam logic [7:0] MASK_CONT   = 8'hC0;
  localparam logic [7:0] PAT_LEAD2   = 8'hC0;
  localparam logic [7:0] PAT_LEAD3   = 8'hE0;
  localparam logic [7:0] PAT_LEAD4   = 8'hF0;
  localparam logic [7:0] PAT_CONT    = 8'h80;

  // Lead lengths (continuation bytes that follow the lead)
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_TWO  = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR = 2'd3;

endpackage

// ===== sv/utf8_stream_validator.sv =====
// Streaming restricted UTF-8 checker: one byte per transaction, one verdict per string.
// Depends on u8v_pkg for code point limits and byte class masks.
//
// Feed a string one byte per transaction with in_last_byte set on its final
// byte; a single out_text_valid result follows for that string, and all parse
// state clears for the next one. Throughput is one byte per clock: each byte
// is captured in an input register, decoded against the parse state in
// shallow logic, and a verdict lands in the output register. The final byte
// passes through the input register and then the output register. Bytes that are not final
// keep flowing while a verdict waits on out_stall; only a final byte stalls
// behind an untaken verdict.
module utf8_stream_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_text_valid
);
  import u8v_pkg::*;

  // Input register
  logic            s1_vld_r;
  logic [7:0]      s1_byte_r;
  logic            s1_last_r;
  logic            s1_adv;

  // Parse state
  logic [1:0]      owed_r,  owed_nxt;
  logic [1:0]      lead_r,  lead_nxt;
  logic [CP_W-1:0] acc_r,   acc_nxt;
  logic            err_r,   err_nxt;

  // Output register
  logic            out_vld_r;
  logic            txt_ok_r;

  logic [CP_W-1:0] acc_shift;
  logic [CP_W-1:0] cp_min;

  // Move the held byte on unless it is final and the verdict slot is still full
  assign s1_adv   = s1_vld_r && (!s1_last_r || !out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;

  // Capture an incoming byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Decode one byte against the parse state
  assign acc_shift = {acc_r[CP_W-7:0], s1_byte_r[5:0]};

  always_comb begin
    case (lead_r)
      LEN_TWO:   cp_min = MIN_2BYTE;
      LEN_THREE: cp_min = MIN_3BYTE;
      default:   cp_min = MIN_4BYTE;
    endcase
  end

  always_comb begin
    owed_nxt = owed_r;
    lead_nxt = lead_r;
    acc_nxt  = acc_r;
    err_nxt  = err_r;
    if (owed_r == 2'd0) begin
      // Lead position
      if (s1_byte_r < ASCII_TOP) begin
        if (s1_byte_r < ASCII_SPACE || s1_byte_r == ASCII_DEL) begin
          err_nxt = 1'b1;
        end
      end else if ((s1_byte_r & MASK_LEAD2) == PAT_LEAD2) begin
        lead_nxt = LEN_TWO;
        owed_nxt = LEN_TWO;
        acc_nxt  = CP_W'(s1_byte_r[4:0]);
      end else if ((s1_byte_r & MASK_LEAD3) == PAT_LEAD3) begin
        lead_nxt = LEN_THREE;
        owed_nxt = LEN_THREE;
        acc_nxt  = CP_W'(s1_byte_r[3:0]);
      end else if ((s1_byte_r & MASK_LEAD4) == PAT_LEAD4) begin
        lead_nxt = LEN_FOUR;
        owed_nxt = LEN_FOUR;
        acc_nxt  = CP_W'(s1_byte_r[2:0]);
      end else begin
        err_nxt = 1'b1;
      end
    end else begin
      // Continuation position: a malformed byte still takes its slot
      if ((s1_byte_r & MASK_CONT) != PAT_CONT) begin
        err_nxt = 1'b1;
      end
      acc_nxt  = acc_shift;
      owed_nxt = owed_r - 2'd1;
      if (owed_r == 2'd1) begin
        // Sequence complete: reject overlong, out of range and surrogates
        if (acc_shift < cp_min || acc_shift > CP_MAX ||
            (acc_shift >= SURR_LO && acc_shift <= SURR_HI)) begin
          err_nxt = 1'b1;
        end
        lead_nxt = LEN_NONE;
        acc_nxt  = '0;
      end
    end
  end

  // Advance parse state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= 2'd0;
      lead_r <= LEN_NONE;
      acc_r  <= '0;
      err_r  <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        owed_r <= 2'd0;
        lead_r <= LEN_NONE;
        acc_r  <= '0;
        err_r  <= 1'b0;
      end else begin
        owed_r <= owed_nxt;
        lead_r <= lead_nxt;
        acc_r  <= acc_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  // Hold the verdict until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      txt_ok_r <= !err_nxt && (owed_nxt == 2'd0);
    end
  end

  assign out_valid      = out_vld_r;
  assign out_text_valid = txt_ok_r;

  // Checks
  a_owed_within_lead: assert property (@(posedge clk) disable iff (!rst_n)
    owed_r != 2'd0 |-> (lead_r != LEN_NONE && owed_r <= lead_r))
    else $error("owed continuations exceed lead length");

  a_accum_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    lead_r == LEN_NONE |-> acc_r == '0)
    else $error("accumulator not clear between sequences");

  a_state_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (owed_r == 2'd0 && err_r == 1'b0))
    else $error("parse state not cleared after final byte");

  a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_adv && s1_last_r))
    else $error("verdict without a final byte");

endmodule
